>>> hw/rtl/gppig_pkg.sv
// Shared types and constants for the micropanel packing index generator.
package gppig_pkg;

   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int ROW_COUNT_W   = 13;
   localparam int DEPTH_USED_W  = 9;
   localparam int LEAD_DIM_W    = 16;
   localparam int INDEX_W       = 32;
   localparam int ROW_CMP_W     = 17;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TRANSPOSE  = 3'd0,
      CSR_OPERAND_B  = 3'd1,
      CSR_ROW_COUNT  = 3'd2,
      CSR_DEPTH_USED = 3'd3,
      CSR_LEAD_DIM   = 3'd4
   } csr_index_type;

endpackage

>>> hw/rtl/gemm_panel_pack_index_gen.sv
// Top level of the micropanel packing index generator.
//
// Each request transaction produces exactly one response transaction that
// carries the source element index of the next packed slot, one slot per
// cycle when the response side keeps up. The slot counters, one multiply
// and one add sit between the request handshake and the response register.
// A two-entry output stage lets a request be taken while a finished
// response still waits to be taken. Configuration registers must be
// written through the csr port only while no transaction is in flight;
// the block itself does not enforce this.
module gemm_panel_pack_index_gen #(
   parameter int A_PANEL_WIDTH = 8,
   parameter int B_PANEL_WIDTH = 8,
   parameter int DEPTH_BLOCK   = 256,
   parameter int MAX_ROWS      = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [gppig_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [gppig_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [0] restart, [7:1] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gppig_pkg::INDEX_W-1:0]     rsp_tdata,  // [31:0] source_index
   output logic [1:0]                        rsp_tuser,  // [0] is_pad, [1] panel_end
   output logic                              rsp_tlast
);

   localparam int MAX_W   = (A_PANEL_WIDTH > B_PANEL_WIDTH) ? A_PANEL_WIDTH : B_PANEL_WIDTH;
   localparam int LANE_W  = (MAX_W > 1) ? $clog2(MAX_W) : 1;
   localparam int DSTEP_W = (DEPTH_BLOCK > 1) ? $clog2(DEPTH_BLOCK) : 1;
   localparam int KCMP_W  = (DSTEP_W > gppig_pkg::DEPTH_USED_W) ? DSTEP_W
                                                               : gppig_pkg::DEPTH_USED_W;
   localparam int R_W     = gppig_pkg::ROW_COUNT_W + 1;
   localparam int MUL_A_W = (R_W > DSTEP_W) ? R_W : DSTEP_W;
   localparam int PROD_W  = MUL_A_W + gppig_pkg::LEAD_DIM_W;

   // Configuration registers.
   logic                                 transpose_ff;
   logic                                 operand_b_ff;
   logic [gppig_pkg::ROW_COUNT_W-1:0]    row_count_ff;
   logic [gppig_pkg::DEPTH_USED_W-1:0]   depth_used_ff;
   logic [gppig_pkg::LEAD_DIM_W-1:0]     lead_dim_ff;

   // Slot counters.
   logic [gppig_pkg::ROW_COUNT_W-1:0]    panel_base_ff, panel_base_in;
   logic [DSTEP_W-1:0]                   depth_step_ff, depth_step_in;
   logic [LANE_W-1:0]                    lane_step_ff, lane_step_in;

   // Output register and skid register.
   logic                                 out_valid_ff;
   logic [gppig_pkg::INDEX_W-1:0]        out_index_ff;
   logic                                 out_pad_ff, out_pend_ff, out_last_ff;
   logic                                 skid_valid_ff;
   logic [gppig_pkg::INDEX_W-1:0]        skid_index_ff;
   logic                                 skid_pad_ff, skid_pend_ff, skid_last_ff;

   logic                                 req_fire;
   logic                                 out_free;
   logic                                 restart;
   logic [gppig_pkg::ROW_COUNT_W-1:0]    base_cur;
   logic [DSTEP_W-1:0]                   k_cur;
   logic [LANE_W-1:0]                    lane_cur;
   logic [LANE_W:0]                      width;
   logic [R_W-1:0]                       r_cur;
   logic [R_W-1:0]                       base_next;
   logic                                 pad_k, pad_r, pad;
   logic                                 row_end, pan_end, job_end;
   logic                                 swap;
   logic [MUL_A_W-1:0]                   mul_a, add_b;
   logic [PROD_W-1:0]                    product;
   logic [gppig_pkg::INDEX_W-1:0]        index_in;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = !skid_valid_ff;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign restart    = req_tdata[0];

   assign base_cur = restart ? '0 : panel_base_ff;
   assign k_cur    = restart ? '0 : depth_step_ff;
   assign lane_cur = restart ? '0 : lane_step_ff;
   assign width    = operand_b_ff ? (LANE_W+1)'(B_PANEL_WIDTH) : (LANE_W+1)'(A_PANEL_WIDTH);

   assign r_cur     = R_W'(base_cur) + R_W'(lane_cur);
   assign base_next = R_W'(base_cur) + R_W'(width);

   assign pad_k = KCMP_W'(k_cur) >= KCMP_W'(depth_used_ff);
   assign pad_r = (gppig_pkg::ROW_CMP_W'(r_cur) >= gppig_pkg::ROW_CMP_W'(row_count_ff)) ||
                  (gppig_pkg::ROW_CMP_W'(r_cur) >= gppig_pkg::ROW_CMP_W'(MAX_ROWS));
   assign pad   = pad_k || pad_r;

   assign row_end = ((LANE_W+1)'(lane_cur) + (LANE_W+1)'(1)) >= width;
   assign pan_end = row_end &&
                    ((DSTEP_W+1)'(k_cur) + (DSTEP_W+1)'(1) >= (DSTEP_W+1)'(DEPTH_BLOCK));
   assign job_end = pan_end &&
                    ((gppig_pkg::ROW_CMP_W'(base_next) >= gppig_pkg::ROW_CMP_W'(row_count_ff)) ||
                     (gppig_pkg::ROW_CMP_W'(base_next) >= gppig_pkg::ROW_CMP_W'(MAX_ROWS)));

   assign swap     = transpose_ff ^ operand_b_ff;
   assign mul_a    = swap ? MUL_A_W'(r_cur) : MUL_A_W'(k_cur);
   assign add_b    = swap ? MUL_A_W'(k_cur) : MUL_A_W'(r_cur);
   assign product  = PROD_W'(mul_a) * PROD_W'(lead_dim_ff);
   assign index_in = pad ? '0 : (gppig_pkg::INDEX_W'(product) + gppig_pkg::INDEX_W'(add_b));

   always_comb begin
      lane_step_in  = lane_cur;
      depth_step_in = k_cur;
      panel_base_in = base_cur;
      if (!row_end) begin
         lane_step_in = lane_cur + LANE_W'(1);
      end else begin
         lane_step_in = '0;
         if (!pan_end) begin
            depth_step_in = k_cur + DSTEP_W'(1);
         end else begin
            depth_step_in = '0;
            panel_base_in = job_end ? '0 : base_next[gppig_pkg::ROW_COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         transpose_ff  <= 1'b0;
         operand_b_ff  <= 1'b0;
         row_count_ff  <= gppig_pkg::ROW_COUNT_W'(1);
         depth_used_ff <= '0;
         lead_dim_ff   <= gppig_pkg::LEAD_DIM_W'(1);
      end else if (csr_we) begin
         case (csr_addr)
            gppig_pkg::CSR_TRANSPOSE:  transpose_ff  <= csr_wdata[0];
            gppig_pkg::CSR_OPERAND_B:  operand_b_ff  <= csr_wdata[0];
            gppig_pkg::CSR_ROW_COUNT:  row_count_ff  <= csr_wdata[gppig_pkg::ROW_COUNT_W-1:0];
            gppig_pkg::CSR_DEPTH_USED: depth_used_ff <= csr_wdata[gppig_pkg::DEPTH_USED_W-1:0];
            gppig_pkg::CSR_LEAD_DIM:   lead_dim_ff   <= csr_wdata[gppig_pkg::LEAD_DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_base_ff <= '0;
         depth_step_ff <= '0;
         lane_step_ff  <= '0;
      end else if (req_fire) begin
         panel_base_ff <= panel_base_in;
         depth_step_ff <= depth_step_in;
         lane_step_ff  <= lane_step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_fire;
         end
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_index_ff <= skid_index_ff;
            out_pad_ff   <= skid_pad_ff;
            out_pend_ff  <= skid_pend_ff;
            out_last_ff  <= skid_last_ff;
         end else if (req_fire) begin
            out_index_ff <= index_in;
            out_pad_ff   <= pad;
            out_pend_ff  <= pan_end;
            out_last_ff  <= job_end;
         end
      end else if (req_fire) begin
         skid_index_ff <= index_in;
         skid_pad_ff   <= pad;
         skid_pend_ff  <= pan_end;
         skid_last_ff  <= job_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_index_ff;
   assign rsp_tuser  = {out_pend_ff, out_pad_ff};
   assign rsp_tlast  = out_last_ff;

   a_last_ends_panel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1])
      else $error("Job end without panel end.");

   a_pad_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("Padding slot carries a nonzero index.");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid register holds a transaction while the output is empty.");

   a_lane_in_range: assert property (@(posedge clock) disable iff (reset)
      (LANE_W+1)'(lane_step_ff) < (LANE_W+1)'(MAX_W))
      else $error("Lane counter out of range.");

   a_depth_in_range: assert property (@(posedge clock) disable iff (reset)
      (DSTEP_W+1)'(depth_step_ff) < (DSTEP_W+1)'(DEPTH_BLOCK))
      else $error("Depth counter out of range.");

endmodule

>>> dv/tb.sv
// Self-checking testbench for the micropanel packing index generator.
`timescale 1ns / 100ps

module tb;

   localparam int A_WIDTH      = 8;
   localparam int B_WIDTH      = 8;
   localparam int DEPTH_BLK    = 256;
   localparam int ROWS_MAX     = 4096;
   localparam int RANDOM_SLOTS = 1525;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [gppig_pkg::INDEX_W-1:0] index;
      logic                          pad;
      logic                          panel_end;
      logic                          job_end;
   } slot_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_we = 1'b0;
   logic [gppig_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [gppig_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata = '0;  // [0] restart, [7:1] zero
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [gppig_pkg::INDEX_W-1:0]    rsp_tdata;       // [31:0] source_index
   logic [1:0]                       rsp_tuser;       // [0] is_pad, [1] panel_end
   logic                             rsp_tlast;

   gemm_panel_pack_index_gen #(
      .A_PANEL_WIDTH(A_WIDTH),
      .B_PANEL_WIDTH(B_WIDTH),
      .DEPTH_BLOCK  (DEPTH_BLK),
      .MAX_ROWS     (ROWS_MAX)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stimulus and expectation storage.
   logic     restart_q[$];
   slot_type expected_slots[$];
   logic     req_fire = 1'b0;
   bit       idle_on = 1'b0;
   int       hold_requests = 0;
   int       holds_served = 0;
   int       hold_left = 0;
   int       req_gap = 0;
   int       rsp_gap = 0;
   int       cycles = 0;
   int       errors = 0;

   // Shadow configuration and slot position.
   bit          cfg_transpose;
   bit          cfg_operand_b;
   int unsigned cfg_row_count;
   int unsigned cfg_depth_used;
   int unsigned cfg_lead_dim;
   longint unsigned pos_base;
   longint unsigned pos_depth;
   longint unsigned pos_lane;

   task automatic clear_shadow();
      cfg_transpose  = 1'b0;
      cfg_operand_b  = 1'b0;
      cfg_row_count  = 1;
      cfg_depth_used = 0;
      cfg_lead_dim   = 1;
      pos_base       = 0;
      pos_depth      = 0;
      pos_lane       = 0;
   endtask

   function automatic slot_type next_slot(input logic restart);
      longint unsigned width, rows, depth, r, k, idx;
      logic            row_end;
      slot_type        s;
      width = cfg_operand_b ? B_WIDTH : A_WIDTH;
      rows  = (cfg_row_count > ROWS_MAX) ? ROWS_MAX : cfg_row_count;
      depth = (cfg_depth_used > DEPTH_BLK) ? DEPTH_BLK : cfg_depth_used;
      if (restart) begin
         pos_base  = 0;
         pos_depth = 0;
         pos_lane  = 0;
      end
      r     = pos_base + pos_lane;
      k     = pos_depth;
      idx   = 0;
      s.pad = (k >= depth) || (r >= rows);
      if (!s.pad) begin
         if (cfg_transpose ^ cfg_operand_b) begin
            idx = k + r * cfg_lead_dim;
         end else begin
            idx = r + k * cfg_lead_dim;
         end
      end
      s.index     = idx[gppig_pkg::INDEX_W-1:0];
      row_end     = (pos_lane + 1 >= width);
      s.panel_end = row_end && (pos_depth + 1 >= DEPTH_BLK);
      s.job_end   = s.panel_end && (pos_base + width >= rows);
      if (!row_end) begin
         pos_lane++;
      end else begin
         pos_lane = 0;
         if (!s.panel_end) begin
            pos_depth++;
         end else begin
            pos_depth = 0;
            pos_base  = s.job_end ? 0 : pos_base + width;
         end
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= 100) $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   // Monitor: checks responses and predicts each accepted request.
   always @(posedge clock) begin : monitor
      slot_type got;
      slot_type want;
      cycles   <= cycles + 1;
      req_fire <= req_tvalid && req_tready && !reset;
      if (cycles == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else if (reset) begin
         clear_shadow();
         expected_slots.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast};
            if (expected_slots.size() == 0) begin
               report_mismatch($sformatf("unexpected response %h", got));
            end else begin
               want = expected_slots.pop_front();
               if (got.index !== want.index)
                  report_mismatch($sformatf("source_index %h, expected %h",
                                            got.index, want.index));
               if (got.pad !== want.pad)
                  report_mismatch($sformatf("is_pad %b, expected %b", got.pad, want.pad));
               if (got.panel_end !== want.panel_end)
                  report_mismatch($sformatf("panel_end %b, expected %b",
                                            got.panel_end, want.panel_end));
               if (got.job_end !== want.job_end)
                  report_mismatch($sformatf("last %b, expected %b",
                                            got.job_end, want.job_end));
            end
         end
         if (req_tvalid && req_tready) expected_slots.push_back(next_slot(req_tdata[0]));
         if (csr_we) begin
            case (gppig_pkg::csr_index_type'(csr_addr))
               gppig_pkg::CSR_TRANSPOSE:  cfg_transpose  = csr_wdata[0];
               gppig_pkg::CSR_OPERAND_B:  cfg_operand_b  = csr_wdata[0];
               gppig_pkg::CSR_ROW_COUNT:
                  cfg_row_count  = csr_wdata[gppig_pkg::ROW_COUNT_W-1:0];
               gppig_pkg::CSR_DEPTH_USED:
                  cfg_depth_used = csr_wdata[gppig_pkg::DEPTH_USED_W-1:0];
               gppig_pkg::CSR_LEAD_DIM:
                  cfg_lead_dim   = csr_wdata[gppig_pkg::LEAD_DIM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Request driver: offers the head of the pending queue with random gaps.
   always @(negedge clock) begin : driver
      logic       next_valid;
      logic [7:0] next_data;
      next_valid = req_tvalid;
      next_data  = req_tdata;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_fire) begin
            restart_q.delete(0);
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 9);
            end else if (restart_q.size() > 0) begin
               next_valid = 1'b1;
               next_data  = {7'b0, restart_q[0]};
            end
         end
      end
      req_tvalid <= next_valid;
      req_tdata  <= next_data;
   end

   // Response side: random stalls plus an occasional long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = 399;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_csr(input gppig_pkg::csr_index_type which,
                            input logic [gppig_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= which;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_config(input bit transpose, input bit operand_b, input int rows,
                             input int depth, input int lead);
      write_csr(gppig_pkg::CSR_TRANSPOSE, gppig_pkg::CSR_DATA_W'(transpose));
      write_csr(gppig_pkg::CSR_OPERAND_B, gppig_pkg::CSR_DATA_W'(operand_b));
      write_csr(gppig_pkg::CSR_ROW_COUNT, gppig_pkg::CSR_DATA_W'(rows));
      write_csr(gppig_pkg::CSR_DEPTH_USED, gppig_pkg::CSR_DATA_W'(depth));
      write_csr(gppig_pkg::CSR_LEAD_DIM, gppig_pkg::CSR_DATA_W'(lead));
   endtask

   // A restart_odds of zero means no restarts after the first slot.
   task automatic offer_slots(input bit first_restart, input int count, input int restart_odds);
      restart_q.push_back(first_restart);
      for (int i = 1; i < count; i++) begin
         restart_q.push_back(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
      end
   endtask

   task automatic wait_idle();
      while (restart_q.size() != 0 || req_tvalid || expected_slots.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   initial begin : stimulus
      int rows;
      int depth;
      int lead;
      int sent;
      int count;
      int phase;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part.
      offer_slots(1'b1, 2, 0);
      wait_idle();
      set_config(1'b0, 1'b0, 5, 3, 100);
      offer_slots(1'b1, 10, 0);
      wait_idle();
      set_config(1'b1, 1'b0, 5, 3, 100);
      offer_slots(1'b1, 3, 0);
      wait_idle();
      set_config(1'b1, 1'b1, 9, 2, 77);
      offer_slots(1'b1, 3, 0);
      wait_idle();
      set_config(1'b0, 1'b1, 8191, 511, 65535);
      offer_slots(1'b1, 3, 0);
      wait_idle();
      set_config(1'b0, 1'b0, 0, 256, 1);
      offer_slots(1'b1, 2, 0);
      wait_idle();

      // Random phases: mostly runs without restart; configuration changes
      // between phases keep the slot position.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_SLOTS) begin
         case ($urandom_range(0, 9))
            0:       rows = 0;
            1:       rows = $urandom_range(ROWS_MAX + 1, 8191);
            2:       rows = ROWS_MAX;
            3:       rows = $urandom_range(17, ROWS_MAX - 1);
            default: rows = $urandom_range(1, 16);
         endcase
         case ($urandom_range(0, 7))
            0:       depth = 0;
            1:       depth = DEPTH_BLK;
            2:       depth = $urandom_range(DEPTH_BLK + 1, 511);
            3:       depth = 1;
            default: depth = $urandom_range(1, DEPTH_BLK - 1);
         endcase
         case ($urandom_range(0, 7))
            0:       lead = 65535;
            1:       lead = 1;
            2:       lead = 0;
            default: lead = $urandom_range(1, 65535);
         endcase
         set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rows, depth, lead);
         idle_on = ($urandom_range(0, 3) != 0);
         count   = $urandom_range(100, 400);
         if (count > RANDOM_SLOTS - sent) count = RANDOM_SLOTS - sent;
         if ($urandom_range(0, 3) == 0) begin
            offer_slots(1'($urandom_range(0, 1)), count, 40);
         end else begin
            offer_slots($urandom_range(0, 9) == 0, count, 0);
         end
         if (phase % 8 == 0) hold_requests++;
         sent += count;
         phase++;
         wait_idle();
      end

      // Closing stretch without idling.
      idle_on = 1'b0;
      offer_slots(1'b0, 200, 0);
      wait_idle();
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
